// ===== hw/rtl/sefb_pkg.sv =====
package sefb_pkg;

	localparam logic [7:0] StxByte = 8'h02;
	localparam logic [7:0] EtxByte = 8'h03;
	// reflected Dallas/Maxim polynomial
	localparam logic [7:0] CrcPoly = 8'h8C;

	localparam int CmdqDepth = 2;
	localparam int CmdqPtrW  = $clog2(CmdqDepth);
	localparam int CmdqCntW  = $clog2(CmdqDepth + 1);

	// one classified item: which parts of the frame it produces
	typedef struct packed {
		logic       start;
		logic       has_data;
		logic       close;
		logic [7:0] msg_type;
		logic [7:0] payload_len;
		logic [7:0] data_byte;
	} sefb_cmd_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/sefb_front.sv =====
module sefb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          msg_type,
	input  logic [7:0]          payload_len,
	input  logic [7:0]          data_byte,
	input  logic                q_full,
	output logic                push,
	output sefb_pkg::sefb_cmd_t cmd
);
	import sefb_pkg::*;

	logic       in_frame_q;
	logic [7:0] left_q;
	logic [7:0] left_nxt;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		cmd.msg_type    = msg_type;
		cmd.payload_len = payload_len;
		cmd.data_byte   = data_byte;
		if (!in_frame_q) begin
			cmd.start    = 1'b1;
			cmd.has_data = (payload_len != 8'd0);
			cmd.close    = (payload_len <= 8'd1);
			left_nxt     = (payload_len != 8'd0) ? payload_len - 8'd1 : 8'd0;
		end else begin
			cmd.start    = 1'b0;
			cmd.has_data = 1'b1;
			cmd.close    = (left_q <= 8'd1);
			left_nxt     = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			left_q     <= 8'd0;
		end else if (push) begin
			in_frame_q <= !cmd.close;
			left_q     <= cmd.close ? 8'd0 : left_nxt;
		end
	end

endmodule

// ===== hw/rtl/sefb_cmdq.sv =====
module sefb_cmdq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sefb_pkg::sefb_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output sefb_pkg::sefb_cmd_t head_cmd
);
	import sefb_pkg::*;

	sefb_cmd_t           mem_q [CmdqDepth];
	logic [CmdqPtrW-1:0] wr_ptr_q;
	logic [CmdqPtrW-1:0] rd_ptr_q;
	logic [CmdqCntW-1:0] count_q;

	assign full       = (count_q == CmdqCntW'(CmdqDepth));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/sefb_back.sv =====
module sefb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  sefb_pkg::sefb_cmd_t head_cmd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last_of_item,
	output logic                end_of_frame
);
	import sefb_pkg::*;

	typedef enum logic [5:0] {
		PH_STX  = 6'b000001,
		PH_TYPE = 6'b000010,
		PH_LEN  = 6'b000100,
		PH_DATA = 6'b001000,
		PH_CRC  = 6'b010000,
		PH_ETX  = 6'b100000
	} sefb_phase_t;

	sefb_phase_t pos_q;
	logic        mid_q;
	logic [7:0]  crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        eof_q;

	sefb_phase_t cur_phase;
	sefb_phase_t nxt_phase;
	logic        done;
	logic        emit;
	logic [7:0]  byte_sel;

	assign cur_phase = mid_q ? pos_q : (head_cmd.start ? PH_STX : PH_DATA);
	assign emit      = head_valid && (!out_valid_q || out_ready);
	assign pop       = emit && done;

	always_comb begin
		nxt_phase = PH_STX;
		done      = 1'b0;
		byte_sel  = StxByte;
		unique case (cur_phase)
			PH_STX: begin
				byte_sel  = StxByte;
				nxt_phase = PH_TYPE;
			end
			PH_TYPE: begin
				byte_sel  = head_cmd.msg_type;
				nxt_phase = PH_LEN;
			end
			PH_LEN: begin
				byte_sel  = head_cmd.payload_len;
				nxt_phase = head_cmd.has_data ? PH_DATA : PH_CRC;
			end
			PH_DATA: begin
				byte_sel  = head_cmd.data_byte;
				nxt_phase = PH_CRC;
				done      = !head_cmd.close;
			end
			PH_CRC: begin
				byte_sel  = crc_q;
				nxt_phase = PH_ETX;
			end
			PH_ETX: begin
				byte_sel = EtxByte;
				done     = 1'b1;
			end
			default: begin
				byte_sel = StxByte;
				done     = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= PH_STX;
			mid_q       <= 1'b0;
			crc_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				mid_q       <= !done;
				if (!done) begin
					pos_q <= nxt_phase;
				end
				unique case (cur_phase)
					PH_STX, PH_ETX:           crc_q <= 8'd0;
					PH_TYPE, PH_LEN, PH_DATA: crc_q <= crc8_byte(crc_q, byte_sel);
					default:                  crc_q <= crc_q;
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_sel;
			last_q     <= done;
			eof_q      <= (cur_phase == PH_ETX);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = last_q;
	assign end_of_frame = eof_q;

`ifndef SYNTHESIS
	a_eof_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eof_q) |-> last_q)
		else $error("ETX not marked as last byte of its item");
	a_mid_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		mid_q |-> head_valid)
		else $error("item in progress lost its queue entry");
	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cur_phase == PH_ETX) |=> (crc_q == 8'd0))
		else $error("CRC not cleared after frame end");
	a_pos_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		mid_q |-> $onehot(pos_q))
		else $error("phase register not one-hot");
`endif

endmodule

// ===== hw/rtl/stx_etx_crc8_frame_builder.sv =====
// channel | signals                                   | direction
// in      | in_valid/in_ready: msg_type, payload_len, | into block
//         |   data_byte                                |
// out     | out_valid/out_ready: out_byte,            | out of block
//         |   last_of_item, end_of_frame              |
//
// Each item is classified in the cycle it is taken and queued (two entries).
// The emitter sends one byte per cycle from the queue head unless stalled:
// a data byte, CRC and ETX on close, and STX, type, length at frame start.
// Output byte rate is one per cycle unless stalled, set by the single-byte emitter.
// arst_n clears the frame state, the queue and the output valid flag.
// A stall on out_ready backs up the queue; in_ready drops when it is full.
module stx_etx_crc8_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] msg_type,
	input  logic [7:0] payload_len,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_item,
	output logic       end_of_frame
);
	import sefb_pkg::*;

	sefb_cmd_t push_cmd;
	sefb_cmd_t head_cmd;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      head_valid;

	sefb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.msg_type    (msg_type),
		.payload_len (payload_len),
		.data_byte   (data_byte),
		.q_full      (q_full),
		.push        (push),
		.cmd         (push_cmd)
	);

	sefb_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	sefb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_item (last_of_item),
		.end_of_frame (end_of_frame)
	);

endmodule
